// ===== rtl/vng_pkg.sv =====
package vng_pkg;

  localparam int N_VTX     = 1024;
  localparam int VTX_W     = 10;
  localparam int POS_W     = 16;
  localparam int SUM_W     = 24;
  localparam int SUM_ENT_W = 1 + 3 * SUM_W;
  localparam int DIFF_W    = POS_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int CROSS_W   = PROD_W + 1;
  localparam int MAG_W     = CROSS_W - 1;
  localparam int NRM_W     = 16;
  localparam int RED_W     = 20;
  localparam int SQ_W      = 2 * RED_W;
  localparam int L2_W      = SQ_W + 2;
  localparam int LEN_W     = L2_W / 2;
  localparam int QB        = 14;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_TRI   = 2'd1,
    MODE_READ  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
  } norm_req_t;

  typedef struct packed {
    logic [2:0][NRM_W-1:0] n;
    logic                  ok;
  } norm_res_t;

endpackage

// ===== rtl/vertex_normal_generator.sv =====
// channel  direction  handshake            payload
// in       into       in_valid / in_stall   mode, index_a, index_b, index_c, coord_x/y/z
// out      out of     out_valid / out_stall vertex_index, normal_x/y/z, has_normal
// writes are stored on acceptance and leave the block idle; reads and triangles pass through the
// bit-serial square root and the three 16-step divisions in the normaliser
// a read of an unreferenced vertex skips the normaliser, and a degenerate face is not accumulated
// clear items and reset run a sweep over all 1024 entries of the sum memory, no request taken
// a read result waits in the output register while the next request is taken
module vertex_normal_generator (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             mode,
  input  logic [9:0]             index_a,
  input  logic [9:0]             index_b,
  input  logic [9:0]             index_c,
  input  logic signed [15:0]     coord_x,
  input  logic signed [15:0]     coord_y,
  input  logic signed [15:0]     coord_z,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [9:0]             vertex_index,
  output logic signed [15:0]     normal_x,
  output logic signed [15:0]     normal_y,
  output logic signed [15:0]     normal_z,
  output logic                   has_normal
);

  typedef enum logic [8:0] {
    S_CLR    = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_POS    = 9'b000000100,
    S_CROSS  = 9'b000001000,
    S_NSTART = 9'b000010000,
    S_NWAIT  = 9'b000100000,
    S_ACC    = 9'b001000000,
    S_RSUM   = 9'b010000000,
    S_OUTW   = 9'b100000000
  } state_t;

  localparam int PW = vng_pkg::POS_W;
  localparam int SW = vng_pkg::SUM_W;

  state_t state;
  vng_pkg::mode_t mode_q;
  logic [vng_pkg::VTX_W-1:0] ia, ib, ic;
  logic [2:0] step;
  logic [vng_pkg::VTX_W-1:0] clr_addr;

  logic [3*PW-1:0] pos_mem [vng_pkg::N_VTX];
  logic [3*PW-1:0] pos_rdata;
  logic [vng_pkg::VTX_W-1:0] pos_raddr;
  logic pos_we;

  logic [vng_pkg::SUM_ENT_W-1:0] sum_mem [vng_pkg::N_VTX];
  logic [vng_pkg::SUM_ENT_W-1:0] sum_rdata;
  logic [vng_pkg::SUM_ENT_W-1:0] sum_wdata;
  logic [vng_pkg::VTX_W-1:0] sum_raddr, sum_waddr, corner;
  logic sum_we;

  logic signed [PW-1:0] pa [3];
  logic signed [PW-1:0] pb [3];
  logic signed [vng_pkg::DIFF_W-1:0] e1 [3];
  logic signed [vng_pkg::DIFF_W-1:0] e2 [3];
  logic signed [vng_pkg::DIFF_W-1:0] mul_a, mul_b;
  logic signed [vng_pkg::PROD_W-1:0] prod;
  logic signed [vng_pkg::CROSS_W-1:0] c [3];
  logic signed [vng_pkg::CROSS_W-1:0] cneg [3];
  logic [2:0] j;
  logic [SW-1:0] sreg [3];
  logic [SW-1:0] sneg [3];

  vng_pkg::norm_req_t req;
  vng_pkg::norm_res_t nres, res;
  logic ndone;
  logic accept;
  logic out_free;

  function automatic logic [SW-1:0] sat_add(logic [SW-1:0] s, logic [vng_pkg::NRM_W-1:0] d);
    logic [SW:0] r;
    r = {s[SW-1], s} + {{(SW + 1 - vng_pkg::NRM_W){d[vng_pkg::NRM_W-1]}}, d};
    if (r[SW] != r[SW-1])
      return r[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    return r[SW-1:0];
  endfunction

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign pos_we   = accept && (vng_pkg::mode_t'(mode) == vng_pkg::MODE_WRITE);
  assign j        = step - 3'd1;

  always_comb begin
    unique case (step[2:1])
      2'd0:    corner = ia;
      2'd1:    corner = ib;
      default: corner = ic;
    endcase
    unique case (step)
      3'd0:    pos_raddr = ia;
      3'd1:    pos_raddr = ib;
      default: pos_raddr = ic;
    endcase
    unique case (step)
      3'd0:    begin mul_a = e2[1]; mul_b = e1[2]; end
      3'd1:    begin mul_a = e2[2]; mul_b = e1[1]; end
      3'd2:    begin mul_a = e2[2]; mul_b = e1[0]; end
      3'd3:    begin mul_a = e2[0]; mul_b = e1[2]; end
      3'd4:    begin mul_a = e2[0]; mul_b = e1[1]; end
      default: begin mul_a = e2[1]; mul_b = e1[0]; end
    endcase
  end

  always_comb begin
    sum_raddr = (state == S_ACC) ? corner : index_a;
    sum_we    = 1'b0;
    sum_waddr = corner;
    sum_wdata = {1'b1, sat_add(sum_rdata[3*SW-1:2*SW], res.n[0]),
                 sat_add(sum_rdata[2*SW-1:SW], res.n[1]),
                 sat_add(sum_rdata[SW-1:0], res.n[2])};
    if (state == S_CLR) begin
      sum_we    = 1'b1;
      sum_waddr = clr_addr;
      sum_wdata = '0;
    end else if (state == S_ACC && step[0]) begin
      sum_we = 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cneg[i] = -c[i];
      sneg[i] = -sreg[i];
      if (mode_q == vng_pkg::MODE_READ) begin
        req.mag[i] = vng_pkg::MAG_W'(sreg[i][SW-1] ? sneg[i] : sreg[i]);
        req.neg[i] = sreg[i][SW-1];
      end else begin
        req.mag[i] = c[i][vng_pkg::CROSS_W-1] ? cneg[i][vng_pkg::MAG_W-1:0]
                                               : c[i][vng_pkg::MAG_W-1:0];
        req.neg[i] = c[i][vng_pkg::CROSS_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[index_a] <= {coord_x, coord_y, coord_z};
    pos_rdata <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    sum_rdata <= sum_mem[sum_raddr];
  end

  vng_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_NSTART),
    .req   (req),
    .done  (ndone),
    .res   (nres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUTW && out_free) out_valid <= 1'b1;
      else if (!out_stall)             out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            mode_q <= vng_pkg::mode_t'(mode);
            ia     <= index_a;
            ib     <= index_b;
            ic     <= index_c;
            step   <= '0;
            unique case (vng_pkg::mode_t'(mode))
              vng_pkg::MODE_WRITE: state <= S_IDLE;
              vng_pkg::MODE_TRI:   state <= S_POS;
              vng_pkg::MODE_READ:  state <= S_RSUM;
              vng_pkg::MODE_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLR;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_POS: begin
          step <= step + 3'd1;
          unique case (step)
            3'd1: begin
              pa[0] <= pos_rdata[3*PW-1:2*PW];
              pa[1] <= pos_rdata[2*PW-1:PW];
              pa[2] <= pos_rdata[PW-1:0];
            end
            3'd2: begin
              pb[0] <= pos_rdata[3*PW-1:2*PW];
              pb[1] <= pos_rdata[2*PW-1:PW];
              pb[2] <= pos_rdata[PW-1:0];
            end
            3'd3: begin
              for (int i = 0; i < 3; i++) begin
                e1[i] <= vng_pkg::DIFF_W'(pb[i]) - vng_pkg::DIFF_W'(pa[i]);
                e2[i] <= vng_pkg::DIFF_W'($signed(pos_rdata[(3-i)*PW-1 -: PW]))
                       - vng_pkg::DIFF_W'(pa[i]);
              end
              step  <= '0;
              state <= S_CROSS;
            end
            default: ;
          endcase
        end
        S_CROSS: begin
          if (step < 3'd6) prod <= mul_a * mul_b;
          if (step != 3'd0) begin
            if (!j[0]) c[j[2:1]] <= vng_pkg::CROSS_W'(prod);
            else       c[j[2:1]] <= c[j[2:1]] - vng_pkg::CROSS_W'(prod);
          end
          step <= step + 3'd1;
          if (step == 3'd6) state <= S_NSTART;
        end
        S_NSTART: state <= S_NWAIT;
        S_NWAIT: begin
          if (ndone) begin
            res  <= nres;
            step <= '0;
            if (mode_q == vng_pkg::MODE_READ) state <= S_OUTW;
            else if (nres.ok)                 state <= S_ACC;
            else                              state <= S_IDLE;
          end
        end
        S_ACC: begin
          step <= step + 3'd1;
          if (step == 3'd5) state <= S_IDLE;
        end
        S_RSUM: begin
          sreg[0] <= sum_rdata[3*SW-1:2*SW];
          sreg[1] <= sum_rdata[2*SW-1:SW];
          sreg[2] <= sum_rdata[SW-1:0];
          if (sum_rdata[vng_pkg::SUM_ENT_W-1]) begin
            state <= S_NSTART;
          end else begin
            res   <= '0;
            state <= S_OUTW;
          end
        end
        S_OUTW: begin
          if (out_free) begin
            vertex_index <= ia;
            normal_x     <= res.n[0];
            normal_y     <= res.n[1];
            normal_z     <= res.n[2];
            has_normal   <= res.ok;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/vng_norm.sv =====
module vng_norm (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  vng_pkg::norm_req_t  req,
  output logic                done,
  output vng_pkg::norm_res_t  res
);

  typedef enum logic [5:0] {
    N_IDLE  = 6'b000001,
    N_SHIFT = 6'b000010,
    N_SQ    = 6'b000100,
    N_SQRT  = 6'b001000,
    N_DIV   = 6'b010000,
    N_FIN   = 6'b100000
  } nstate_t;

  nstate_t state;
  logic [vng_pkg::MAG_W-1:0] a [3];
  logic [2:0] neg;
  logic [4:0] cnt;
  logic [1:0] k;
  logic [vng_pkg::SQ_W-1:0] prod;
  logic [vng_pkg::L2_W-1:0] l2;
  logic [vng_pkg::LEN_W+2:0] rem;
  logic [vng_pkg::LEN_W-1:0] len;
  logic [vng_pkg::LEN_W+4:0] st;
  logic [vng_pkg::LEN_W+1:0] trial;
  logic [vng_pkg::LEN_W-1:0] drem;
  logic [15:0] dsh;
  logic [15:0] q;
  logic [15:0] q_next;
  logic [vng_pkg::LEN_W:0] dt;
  logic [vng_pkg::MAG_W:0] num;
  logic [2:0][vng_pkg::NRM_W-1:0] nreg;
  logic ok;
  logic big;
  logic zero;

  assign big  = |{a[0][vng_pkg::MAG_W-1:vng_pkg::RED_W], a[1][vng_pkg::MAG_W-1:vng_pkg::RED_W],
                  a[2][vng_pkg::MAG_W-1:vng_pkg::RED_W]};
  assign zero = ~|{a[0], a[1], a[2]};
  assign st    = {rem, l2[vng_pkg::L2_W-1 -: 2]};
  assign trial = {len, 2'b01};
  assign dt    = {drem, dsh[15]};
  assign q_next = (dt >= {1'b0, len}) ? {q[14:0], 1'b1} : {q[14:0], 1'b0};
  assign num = {1'b0, a[k][vng_pkg::RED_W-1:0], {vng_pkg::QB{1'b0}}}
             + (vng_pkg::MAG_W + 1)'(len[vng_pkg::LEN_W-1:1]);

  assign done = (state == N_FIN);
  assign res  = {nreg, ok};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      unique case (state)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) a[i] <= req.mag[i];
            neg   <= req.neg;
            state <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (zero) begin
            ok    <= 1'b0;
            nreg  <= '0;
            state <= N_FIN;
          end else if (big) begin
            for (int i = 0; i < 3; i++) a[i] <= a[i] >> 1;
          end else begin
            cnt   <= '0;
            l2    <= '0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          if (cnt < 5'd3)
            prod <= a[cnt[1:0]][vng_pkg::RED_W-1:0] * a[cnt[1:0]][vng_pkg::RED_W-1:0];
          if (cnt != 5'd0) l2 <= l2 + {2'b00, prod};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd3) begin
            cnt   <= '0;
            rem   <= '0;
            len   <= '0;
            state <= N_SQRT;
          end
        end
        N_SQRT: begin
          if (st >= {3'b000, trial}) begin
            rem <= (vng_pkg::LEN_W + 3)'(st - {3'b000, trial});
            len <= {len[vng_pkg::LEN_W-2:0], 1'b1};
          end else begin
            rem <= st[vng_pkg::LEN_W+2:0];
            len <= {len[vng_pkg::LEN_W-2:0], 1'b0};
          end
          l2  <= l2 << 2;
          cnt <= cnt + 5'd1;
          if (cnt == 5'(vng_pkg::LEN_W - 1)) begin
            cnt   <= '0;
            k     <= '0;
            state <= N_DIV;
          end
        end
        N_DIV: begin
          if (cnt == 5'd0) begin
            drem <= vng_pkg::LEN_W'(num[vng_pkg::MAG_W:16]);
            dsh  <= num[15:0];
            q    <= '0;
            cnt  <= 5'd1;
          end else begin
            drem <= (dt >= {1'b0, len}) ? vng_pkg::LEN_W'(dt - {1'b0, len})
                                         : dt[vng_pkg::LEN_W-1:0];
            dsh  <= dsh << 1;
            q    <= q_next;
            cnt  <= cnt + 5'd1;
            if (cnt == 5'd16) begin
              nreg[k] <= neg[k] ? 16'(-q_next) : q_next;
              cnt     <= '0;
              k       <= k + 2'd1;
              if (k == 2'd2) begin
                ok    <= 1'b1;
                state <= N_FIN;
              end
            end
          end
        end
        N_FIN: state <= N_IDLE;
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule
